// ----- design/nepsc_pkg.sv -----
package nepsc_pkg;

    // default configuration
    localparam int COARSE_STEPS_DEF = 64;
    localparam int REFINE_STEPS_DEF = 64;
    localparam int COORD_BITS_DEF   = 32;
    localparam int PHASE_BITS_DEF   = 32;

    // result width and queue depth
    localparam int OUT_BITS   = 34;
    localparam int FIFO_DEPTH = 2;

    // CORDIC: angle in 2^-32 turn, values in Q30, gain pre-compensated
    localparam int                 CORDIC_ITERS = 30;
    localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;

    // golden ratio conjugate in Q32, split into two 16-bit halves
    localparam logic [15:0] GOLD_HI = 16'd40503;
    localparam logic [15:0] GOLD_LO = 16'd31161;

    // arctangent of 2^-i in 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] r;
        unique case (idx)
            5'd0:    r = 32'h2000_0000;
            5'd1:    r = 32'h12E4_051E;
            5'd2:    r = 32'h09FB_385B;
            5'd3:    r = 32'h0511_11D4;
            5'd4:    r = 32'h028B_0D43;
            5'd5:    r = 32'h0145_D7E1;
            5'd6:    r = 32'h00A2_F61E;
            5'd7:    r = 32'h0051_7C55;
            5'd8:    r = 32'h0028_BE53;
            5'd9:    r = 32'h0014_5F2F;
            5'd10:   r = 32'h000A_2F98;
            5'd11:   r = 32'h0005_17CC;
            5'd12:   r = 32'h0002_8BE6;
            5'd13:   r = 32'h0001_45F3;
            5'd14:   r = 32'h0000_A2FA;
            5'd15:   r = 32'h0000_517D;
            5'd16:   r = 32'h0000_28BE;
            5'd17:   r = 32'h0000_145F;
            5'd18:   r = 32'h0000_0A30;
            5'd19:   r = 32'h0000_0518;
            5'd20:   r = 32'h0000_028C;
            5'd21:   r = 32'h0000_0146;
            5'd22:   r = 32'h0000_00A3;
            5'd23:   r = 32'h0000_0051;
            5'd24:   r = 32'h0000_0029;
            5'd25:   r = 32'h0000_0014;
            5'd26:   r = 32'h0000_000A;
            5'd27:   r = 32'h0000_0005;
            5'd28:   r = 32'h0000_0003;
            5'd29:   r = 32'h0000_0001;
            default: r = 32'h0000_0000;
        endcase
        return r;
    endfunction

endpackage

// ----- design/nearest_ellipse_phase_search_core.sv -----
// Nearest phase on a 3-D ellipse: for axes A, B and target T the block returns the phase p
// (2^-PHASE_BITS turn) whose point cos(p)*A + sin(p)*B is nearest T, by a coarse scan of
// COARSE_STEPS phases then REFINE_STEPS golden-section steps, giving the final bracket's
// midpoint. One distance evaluation is a request, 30 CORDIC rotations and their
// hand-back, then serial multiply-accumulate and squaring per axis. A two-entry queue on each
// side lets a new transaction be taken, and a finished result wait, while a search runs.
// All evaluations run one at a time on the single shared evaluator.
module nearest_ellipse_phase_search_core #(
    parameter int COARSE_STEPS = nepsc_pkg::COARSE_STEPS_DEF,
    parameter int REFINE_STEPS = nepsc_pkg::REFINE_STEPS_DEF,
    parameter int COORD_BITS   = nepsc_pkg::COORD_BITS_DEF,
    parameter int PHASE_BITS   = nepsc_pkg::PHASE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic signed [COORD_BITS-1:0]         axis_a_x,
    input  logic signed [COORD_BITS-1:0]         axis_a_y,
    input  logic signed [COORD_BITS-1:0]         axis_a_z,
    input  logic signed [COORD_BITS-1:0]         axis_b_x,
    input  logic signed [COORD_BITS-1:0]         axis_b_y,
    input  logic signed [COORD_BITS-1:0]         axis_b_z,
    input  logic signed [COORD_BITS-1:0]         target_x,
    input  logic signed [COORD_BITS-1:0]         target_y,
    input  logic signed [COORD_BITS-1:0]         target_z,
    output logic                                 empty,
    input  logic                                 pop,
    output logic signed [nepsc_pkg::OUT_BITS-1:0] phase
);

    localparam int IW = 9 * COORD_BITS;

    logic [IW-1:0]                      in_wdata;
    logic [IW-1:0]                      in_rdata;
    logic                               in_empty;
    logic                               in_pop;
    logic                               out_full;
    logic                               out_push;
    logic [nepsc_pkg::OUT_BITS-1:0]     out_wdata;
    logic [nepsc_pkg::OUT_BITS-1:0]     out_rdata;

    assign in_wdata = {target_z, target_y, target_x,
                       axis_b_z, axis_b_y, axis_b_x,
                       axis_a_z, axis_a_y, axis_a_x};

    // front: transaction queue
    nepsc_fifo #(
        .WIDTH (IW),
        .DEPTH (nepsc_pkg::FIFO_DEPTH)
    ) u_in_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (in_wdata),
        .full  (full),
        .pop   (in_pop),
        .rdata (in_rdata),
        .empty (in_empty)
    );

    // back: coarse scan and golden-section refinement
    nepsc_search #(
        .COARSE_STEPS (COARSE_STEPS),
        .REFINE_STEPS (REFINE_STEPS),
        .CB           (COORD_BITS),
        .PB           (PHASE_BITS)
    ) u_search (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_empty (in_empty),
        .in_data  (in_rdata),
        .in_pop   (in_pop),
        .out_full (out_full),
        .out_push (out_push),
        .out_data (out_wdata)
    );

    // result queue
    nepsc_fifo #(
        .WIDTH (nepsc_pkg::OUT_BITS),
        .DEPTH (nepsc_pkg::FIFO_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_wdata),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (empty)
    );

    assign phase = $signed(out_rdata);

endmodule

// ----- design/nepsc_fifo.sv -----
module nepsc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = nepsc_pkg::FIFO_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wptr_reg;
    logic [AW-1:0]    rptr_reg;
    logic [CW-1:0]    count_reg;
    logic             wr;
    logic             rd;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign wr    = push && !full;
    assign rd    = pop && !empty;
    assign rdata = mem[rptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wptr_reg] <= wdata;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr)
            begin
                wptr_reg <= (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (rd)
            begin
                rptr_reg <= (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (wr && !rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd && !wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- design/nepsc_cordic.sv -----
module nepsc_cordic (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [31:0]        angle,
    output logic               done,
    output logic signed [33:0] cos_q,
    output logic signed [33:0] sin_q
);

    logic               busy_reg;
    logic               done_reg;
    logic [4:0]         i_reg;
    logic [1:0]         q_reg;
    logic signed [33:0] x_reg;
    logic signed [33:0] y_reg;
    logic signed [32:0] z_reg;
    logic [31:0]        t;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [32:0] at;

    // quadrant fold into [-1/8, 1/8) turn
    assign t  = angle + 32'h2000_0000;
    assign dx = y_reg >>> i_reg;
    assign dy = x_reg >>> i_reg;
    assign at = $signed({1'b0, nepsc_pkg::atan_turn(i_reg)});

    // one rotation per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= nepsc_pkg::CORDIC_GAIN;
            y_reg <= '0;
            z_reg <= $signed({3'b000, t[29:0]}) - 33'sd536870912;
            q_reg <= t[31:30];
            i_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (z_reg >= 0)
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at;
            end
            i_reg <= i_reg + 1'b1;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && i_reg == 5'(nepsc_pkg::CORDIC_ITERS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign done = done_reg;

    // undo the quadrant fold
    always_comb
    begin
        unique case (q_reg)
            2'd0:
            begin
                cos_q = x_reg;
                sin_q = y_reg;
            end
            2'd1:
            begin
                cos_q = -y_reg;
                sin_q = x_reg;
            end
            2'd2:
            begin
                cos_q = -x_reg;
                sin_q = -y_reg;
            end
            default:
            begin
                cos_q = y_reg;
                sin_q = -x_reg;
            end
        endcase
    end

endmodule

// ----- design/nepsc_eval.sv -----
module nepsc_eval #(
    parameter int CB = nepsc_pkg::COORD_BITS_DEF,
    parameter int PB = nepsc_pkg::PHASE_BITS_DEF,
    parameter int PW = PB + 2,
    parameter int QW = 2 * CB + 14
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [PW-1:0] phase,
    input  logic [3*CB-1:0]      vec_a,
    input  logic [3*CB-1:0]      vec_b,
    input  logic [3*CB-1:0]      vec_t,
    output logic                 done,
    output logic [QW-1:0]        dist_sq
);

    localparam int DW = CB + 36;
    localparam int VW = DW - 30;
    localparam int H  = (VW + 1) / 2;

    typedef enum logic [2:0] {
        E_IDLE,
        E_TRIG,
        E_INIT,
        E_MAC,
        E_ROUND,
        E_SQ
    } eval_state_t;

    eval_state_t        state_reg;
    logic               done_reg;
    logic [1:0]         axis_reg;
    logic [1:0]         step_reg;
    logic signed [33:0] c_reg;
    logic signed [33:0] s_reg;
    logic signed [DW-1:0] acc_reg;
    logic [VW-1:0]      v_reg;
    logic [QW-1:0]      sum_reg;

    logic               cordic_start;
    logic               cordic_done;
    logic signed [33:0] cos_q;
    logic signed [33:0] sin_q;
    logic [PB-1:0]      u;
    logic [31:0]        angle;

    logic signed [CB-1:0]    ca;
    logic signed [CB-1:0]    cbv;
    logic signed [CB-1:0]    ct;
    logic signed [CB-1:0]    mul_a;
    logic signed [17:0]      digit;
    logic signed [CB+17:0]   prod;
    logic signed [DW-1:0]    prod_ext;
    logic signed [DW-1:0]    addend;
    logic signed [DW-1:0]    t_shift;
    logic [DW-1:0]           mag;
    logic [DW-1:0]           rnd;
    logic [VW+H-1:0]         sq_lo;
    logic [2*VW-H-1:0]       sq_hi;
    logic [QW-1:0]           sq_add;

    // phase to 32-bit turn fraction
    assign u = phase[PB-1:0];
    generate
        if (PB >= 32)
        begin : g_down
            assign angle = u[PB-1:PB-32];
        end
        else
        begin : g_up
            assign angle = {u, {(32 - PB){1'b0}}};
        end
    endgenerate

    assign cordic_start = start && (state_reg == E_IDLE);

    nepsc_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .angle (angle),
        .done  (cordic_done),
        .cos_q (cos_q),
        .sin_q (sin_q)
    );

    // coordinate select for the current axis
    always_comb
    begin
        unique case (axis_reg)
            2'd0:
            begin
                ca  = $signed(vec_a[CB-1:0]);
                cbv = $signed(vec_b[CB-1:0]);
                ct  = $signed(vec_t[CB-1:0]);
            end
            2'd1:
            begin
                ca  = $signed(vec_a[2*CB-1:CB]);
                cbv = $signed(vec_b[2*CB-1:CB]);
                ct  = $signed(vec_t[2*CB-1:CB]);
            end
            default:
            begin
                ca  = $signed(vec_a[3*CB-1:2*CB]);
                cbv = $signed(vec_b[3*CB-1:2*CB]);
                ct  = $signed(vec_t[3*CB-1:2*CB]);
            end
        endcase
    end

    // one partial product per cycle: low and high halves of cos, then sin
    always_comb
    begin
        mul_a = step_reg[1] ? cbv : ca;
        unique case (step_reg)
            2'd0:    digit = $signed({1'b0, c_reg[16:0]});
            2'd1:    digit = $signed({c_reg[33], c_reg[33:17]});
            2'd2:    digit = $signed({1'b0, s_reg[16:0]});
            default: digit = $signed({s_reg[33], s_reg[33:17]});
        endcase
        prod     = mul_a * digit;
        prod_ext = DW'(prod);
        addend   = step_reg[0] ? (prod_ext <<< 17) : prod_ext;
        t_shift  = DW'(ct) <<< 30;
    end

    // magnitude, rounded to integer, and its square in two halves
    always_comb
    begin
        mag    = acc_reg[DW-1] ? DW'(-acc_reg) : DW'(acc_reg);
        rnd    = mag + (DW'(1) << 29);
        sq_lo  = (VW+H)'(v_reg) * (VW+H)'(v_reg[H-1:0]);
        sq_hi  = (2*VW-H)'(v_reg) * (2*VW-H)'(v_reg[VW-1:H]);
        sq_add = step_reg[0] ? (QW'(sq_hi) << H) : QW'(sq_lo);
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            done_reg  <= 1'b0;
            axis_reg  <= '0;
            step_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                E_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= E_TRIG;
                    end
                end
                E_TRIG:
                begin
                    if (cordic_done)
                    begin
                        axis_reg  <= '0;
                        state_reg <= E_INIT;
                    end
                end
                E_INIT:
                begin
                    step_reg  <= '0;
                    state_reg <= E_MAC;
                end
                E_MAC:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 2'd3)
                    begin
                        state_reg <= E_ROUND;
                    end
                end
                E_ROUND:
                begin
                    step_reg  <= '0;
                    state_reg <= E_SQ;
                end
                E_SQ:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg[0])
                    begin
                        if (axis_reg == 2'd2)
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= E_IDLE;
                        end
                        else
                        begin
                            axis_reg  <= axis_reg + 1'b1;
                            state_reg <= E_INIT;
                        end
                    end
                end
                default:
                begin
                    state_reg <= E_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == E_IDLE && start)
        begin
            sum_reg <= '0;
        end
        if (state_reg == E_TRIG && cordic_done)
        begin
            c_reg <= cos_q;
            s_reg <= sin_q;
        end
        if (state_reg == E_INIT)
        begin
            acc_reg <= -t_shift;
        end
        if (state_reg == E_MAC)
        begin
            acc_reg <= acc_reg + addend;
        end
        if (state_reg == E_ROUND)
        begin
            v_reg <= rnd[DW-1:30];
        end
        if (state_reg == E_SQ)
        begin
            sum_reg <= sum_reg + sq_add;
        end
    end

    assign done    = done_reg;
    assign dist_sq = sum_reg;

endmodule

// ----- design/nepsc_search.sv -----
module nepsc_search #(
    parameter int COARSE_STEPS = nepsc_pkg::COARSE_STEPS_DEF,
    parameter int REFINE_STEPS = nepsc_pkg::REFINE_STEPS_DEF,
    parameter int CB           = nepsc_pkg::COORD_BITS_DEF,
    parameter int PB           = nepsc_pkg::PHASE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_empty,
    input  logic [9*CB-1:0]               in_data,
    output logic                          in_pop,
    input  logic                          out_full,
    output logic                          out_push,
    output logic [nepsc_pkg::OUT_BITS-1:0] out_data
);

    localparam int PW = PB + 2;
    localparam int QW = 2 * CB + 14;
    localparam int KW = $clog2(COARSE_STEPS);
    localparam int JW = $clog2(REFINE_STEPS + 1);
    localparam int WW = PB - 1;
    localparam int GW = ((WW + 16 > 32) ? WW + 16 : 32) + 1;
    localparam longint unsigned STEP = (64'd1 << PB) / COARSE_STEPS;
    localparam logic signed [PW-1:0] STEP_S = PW'(STEP);

    typedef enum logic [3:0] {
        S_IDLE,
        S_COARSE_START,
        S_COARSE_WAIT,
        S_BRACKET,
        S_CUT1,
        S_CUT2,
        S_APPLY,
        S_LEFT_START,
        S_LEFT_WAIT,
        S_RIGHT_START,
        S_RIGHT_WAIT,
        S_UPDATE,
        S_OUT
    } search_state_t;

    typedef enum logic [1:0] {
        CUT_BOTH,
        CUT_LEFT,
        CUT_RIGHT
    } cut_sel_t;

    search_state_t        state_reg;
    cut_sel_t             sel_reg;
    logic [KW-1:0]        k_reg;
    logic [JW-1:0]        j_reg;
    logic [3*CB-1:0]      va_reg;
    logic [3*CB-1:0]      vb_reg;
    logic [3*CB-1:0]      vt_reg;
    logic signed [PW-1:0] ph_reg;
    logic signed [PW-1:0] bp_reg;
    logic signed [PW-1:0] low_reg;
    logic signed [PW-1:0] high_reg;
    logic signed [PW-1:0] left_reg;
    logic signed [PW-1:0] right_reg;
    logic signed [PW-1:0] cut_reg;
    logic [QW-1:0]        best_reg;
    logic [QW-1:0]        dl_reg;
    logic [QW-1:0]        dr_reg;
    logic [GW-1:0]        p1_reg;
    logic [GW-1:0]        p2_reg;

    logic                 ev_start;
    logic signed [PW-1:0] ev_phase;
    logic                 ev_done;
    logic [QW-1:0]        ev_dist;
    logic [WW-1:0]        w;
    logic [GW:0]          cut_full;
    logic [PW:0]          ends_sum;
    logic [PW-1:0]        mid;

    // evaluation requests
    assign ev_start = (state_reg == S_COARSE_START) || (state_reg == S_LEFT_START)
                   || (state_reg == S_RIGHT_START);
    assign ev_phase = (state_reg == S_LEFT_START) ? left_reg
                    : (state_reg == S_RIGHT_START) ? right_reg : ph_reg;

    nepsc_eval #(
        .CB (CB),
        .PB (PB),
        .PW (PW),
        .QW (QW)
    ) u_eval (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (ev_start),
        .phase   (ev_phase),
        .vec_a   (va_reg),
        .vec_b   (vb_reg),
        .vec_t   (vt_reg),
        .done    (ev_done),
        .dist_sq (ev_dist)
    );

    // golden cut, rounded to nearest
    assign w        = WW'(high_reg - low_reg);
    assign cut_full = ((GW+1)'(p1_reg) + (GW+1)'(p2_reg >> 16)) >> 16;

    // bracket midpoint
    assign ends_sum = (PW+1)'(low_reg) + (PW+1)'(high_reg);
    assign mid      = ends_sum[PW:1];
    assign out_data = nepsc_pkg::OUT_BITS'($signed(mid));

    assign in_pop   = (state_reg == S_IDLE) && !in_empty;
    assign out_push = (state_reg == S_OUT) && !out_full;

    // search sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= CUT_BOTH;
            k_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!in_empty)
                    begin
                        k_reg     <= '0;
                        state_reg <= S_COARSE_START;
                    end
                end
                S_COARSE_START:
                begin
                    state_reg <= S_COARSE_WAIT;
                end
                S_COARSE_WAIT:
                begin
                    if (ev_done)
                    begin
                        if (k_reg == KW'(COARSE_STEPS - 1))
                        begin
                            state_reg <= S_BRACKET;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= S_COARSE_START;
                        end
                    end
                end
                S_BRACKET:
                begin
                    sel_reg   <= CUT_BOTH;
                    j_reg     <= '0;
                    state_reg <= S_CUT1;
                end
                S_CUT1:
                begin
                    state_reg <= S_CUT2;
                end
                S_CUT2:
                begin
                    state_reg <= S_APPLY;
                end
                S_APPLY:
                begin
                    state_reg <= (j_reg == JW'(REFINE_STEPS)) ? S_OUT : S_LEFT_START;
                end
                S_LEFT_START:
                begin
                    state_reg <= S_LEFT_WAIT;
                end
                S_LEFT_WAIT:
                begin
                    if (ev_done)
                    begin
                        state_reg <= S_RIGHT_START;
                    end
                end
                S_RIGHT_START:
                begin
                    state_reg <= S_RIGHT_WAIT;
                end
                S_RIGHT_WAIT:
                begin
                    if (ev_done)
                    begin
                        state_reg <= S_UPDATE;
                    end
                end
                S_UPDATE:
                begin
                    sel_reg   <= (dl_reg < dr_reg) ? CUT_LEFT : CUT_RIGHT;
                    j_reg     <= j_reg + 1'b1;
                    state_reg <= S_CUT1;
                end
                S_OUT:
                begin
                    if (!out_full)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // search datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                va_reg <= in_data[3*CB-1:0];
                vb_reg <= in_data[6*CB-1:3*CB];
                vt_reg <= in_data[9*CB-1:6*CB];
                ph_reg <= '0;
            end
            S_COARSE_WAIT:
            begin
                if (ev_done)
                begin
                    // earliest strict minimum wins
                    if (k_reg == '0 || ev_dist < best_reg)
                    begin
                        best_reg <= ev_dist;
                        bp_reg   <= ph_reg;
                    end
                    ph_reg <= ph_reg + STEP_S;
                end
            end
            S_BRACKET:
            begin
                low_reg  <= bp_reg - STEP_S;
                high_reg <= bp_reg + STEP_S;
            end
            S_CUT1:
            begin
                p1_reg <= GW'(w) * GW'(nepsc_pkg::GOLD_HI);
                p2_reg <= GW'(w) * GW'(nepsc_pkg::GOLD_LO) + (GW'(1) << 31);
            end
            S_CUT2:
            begin
                cut_reg <= PW'(cut_full);
            end
            S_APPLY:
            begin
                unique case (sel_reg)
                    CUT_BOTH:
                    begin
                        left_reg  <= high_reg - cut_reg;
                        right_reg <= low_reg + cut_reg;
                    end
                    CUT_LEFT:
                    begin
                        left_reg <= high_reg - cut_reg;
                    end
                    default:
                    begin
                        right_reg <= low_reg + cut_reg;
                    end
                endcase
            end
            S_LEFT_WAIT:
            begin
                if (ev_done)
                begin
                    dl_reg <= ev_dist;
                end
            end
            S_RIGHT_WAIT:
            begin
                if (ev_done)
                begin
                    dr_reg <= ev_dist;
                end
            end
            S_UPDATE:
            begin
                // a tie moves the bracket up
                if (dl_reg < dr_reg)
                begin
                    high_reg  <= right_reg;
                    right_reg <= left_reg;
                end
                else
                begin
                    low_reg  <= left_reg;
                    left_reg <= right_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // checks
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> !out_full)
        else $error("result pushed into a full queue");

    a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        ev_done |-> (state_reg == S_COARSE_WAIT || state_reg == S_LEFT_WAIT
                     || state_reg == S_RIGHT_WAIT))
        else $error("distance result arrived with no request pending");

    a_bracket_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LEFT_START || state_reg == S_OUT) |-> (low_reg <= high_reg))
        else $error("bracket ends crossed");

    a_pop_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_pop |=> (state_reg == S_COARSE_START))
        else $error("transaction taken without starting the scan");

endmodule
